/* src/kclc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Keypad code lock shared definitions
// Event kinds, lock stages, register indexes, register reset values and the
// structs passed between the configuration block and the lock core.
// ----------------------------------------------------------------------------
package kclc_pkg;

   // Widths of the fixed fields
   localparam int unsigned CodeWidth  = 24;
   localparam int unsigned MsWidth    = 16;
   localparam int unsigned KeyWidth   = 4;
   localparam int unsigned ModeWidth  = 2;
   localparam int unsigned StageWidth = 3;
   localparam int unsigned DigitWidth = 4;
   localparam int unsigned RegIdxWidth = 3;

   // Register reset values
   localparam logic [CodeWidth-1:0] DefaultCodeRst   = 24'h123456;
   localparam logic [MsWidth-1:0]   DebounceMsRst    = 16'd200;
   localparam logic [MsWidth-1:0]   OpenMsRst        = 16'd3000;
   localparam logic [MsWidth-1:0]   WrongUnlockMsRst = 16'd1600;
   localparam logic [MsWidth-1:0]   WrongChangeMsRst = 16'd2000;
   localparam logic [MsWidth-1:0]   ChangedMsRst     = 16'd2000;
   localparam logic [MsWidth-1:0]   ResetNoticeMsRst = 16'd2000;

   // Menu keys
   localparam logic [KeyWidth-1:0] KeyUnlock = 4'd1;
   localparam logic [KeyWidth-1:0] KeyChange = 4'd2;
   localparam logic [KeyWidth-1:0] KeyNone   = 4'd0;

   typedef enum logic [ModeWidth-1:0] {
      MODE_KEY   = 2'd0,
      MODE_TIMER = 2'd1,
      MODE_RESET = 2'd2
   } kclc_mode_type;

   typedef enum logic [StageWidth-1:0] {
      STAGE_MENU     = 3'd0,
      STAGE_TRY_OPEN = 3'd1,
      STAGE_CHANGE   = 3'd2,
      STAGE_OPEN     = 3'd3,
      STAGE_WRONG    = 3'd4,
      STAGE_CODE_SET = 3'd5,
      STAGE_RESTORED = 3'd6
   } kclc_stage_type;

   typedef enum logic [RegIdxWidth-1:0] {
      REG_DEFAULT_CODE    = 3'd0,
      REG_DEBOUNCE_MS     = 3'd1,
      REG_OPEN_MS         = 3'd2,
      REG_WRONG_UNLOCK_MS = 3'd3,
      REG_WRONG_CHANGE_MS = 3'd4,
      REG_CHANGED_MS      = 3'd5,
      REG_RESET_NOTICE_MS = 3'd6
   } kclc_reg_type;

   typedef struct packed {
      logic [CodeWidth-1:0] default_code;
      logic [MsWidth-1:0]   debounce_ms;
      logic [MsWidth-1:0]   open_ms;
      logic [MsWidth-1:0]   wrong_unlock_ms;
      logic [MsWidth-1:0]   wrong_change_ms;
      logic [MsWidth-1:0]   changed_ms;
      logic [MsWidth-1:0]   reset_notice_ms;
   } kclc_cfg_type;

   typedef struct packed {
      logic                 door_open;
      logic                 old_code_verified;
      logic                 last_digit_shown;
      logic [2:0]           digits_entered;
      logic [MsWidth-1:0]   timer_ms;
      logic                 start_timer;
      kclc_stage_type       stage;
   } kclc_rsp_type;

endpackage
`default_nettype wire

/* src/kclc_cfg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Keypad code lock configuration registers
// Holds the default code and the timer durations written over the csr port.
// ----------------------------------------------------------------------------
module kclc_cfg (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_we,
   input  wire logic [kclc_pkg::RegIdxWidth-1:0]   csr_addr,
   input  wire logic [kclc_pkg::CodeWidth-1:0]     csr_wdata,
   output kclc_pkg::kclc_cfg_type                  cfg
);
   import kclc_pkg::*;

   kclc_cfg_type cfg_ff;
   kclc_cfg_type cfg_in;
   logic [MsWidth-1:0] wdata_ms;

   assign wdata_ms = csr_wdata[MsWidth-1:0];

   // Decode the register index
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (kclc_reg_type'(csr_addr))
            REG_DEFAULT_CODE:    cfg_in.default_code    = csr_wdata;
            REG_DEBOUNCE_MS:     cfg_in.debounce_ms     = wdata_ms;
            REG_OPEN_MS:         cfg_in.open_ms         = wdata_ms;
            REG_WRONG_UNLOCK_MS: cfg_in.wrong_unlock_ms = wdata_ms;
            REG_WRONG_CHANGE_MS: cfg_in.wrong_change_ms = wdata_ms;
            REG_CHANGED_MS:      cfg_in.changed_ms      = wdata_ms;
            REG_RESET_NOTICE_MS: cfg_in.reset_notice_ms = wdata_ms;
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.default_code    <= DefaultCodeRst;
         cfg_ff.debounce_ms     <= DebounceMsRst;
         cfg_ff.open_ms         <= OpenMsRst;
         cfg_ff.wrong_unlock_ms <= WrongUnlockMsRst;
         cfg_ff.wrong_change_ms <= WrongChangeMsRst;
         cfg_ff.changed_ms      <= ChangedMsRst;
         cfg_ff.reset_notice_ms <= ResetNoticeMsRst;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

/* src/kclc_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Keypad code lock core
// Holds the lock state and applies one event per cycle, producing the result
// of that event from the updated state.
// ----------------------------------------------------------------------------
module kclc_core #(
   parameter int unsigned CODE_DIGITS = 6
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             evt_fire,
   input  wire logic [kclc_pkg::ModeWidth-1:0]   evt_mode,
   input  wire logic [kclc_pkg::KeyWidth-1:0]    evt_key,
   input  wire kclc_pkg::kclc_cfg_type           cfg,
   output kclc_pkg::kclc_rsp_type                rsp
);
   import kclc_pkg::*;

   localparam int unsigned CntWidth = $clog2(CODE_DIGITS + 1);
   localparam int unsigned IdxWidth = (CODE_DIGITS > 1) ? $clog2(CODE_DIGITS) : 1;
   localparam logic [CntWidth-1:0] LastCount = CntWidth'(CODE_DIGITS - 1);

   kclc_stage_type          stage_ff, stage_in;
   logic [DigitWidth-1:0]   stored_ff [CODE_DIGITS];
   logic [DigitWidth-1:0]   stored_in [CODE_DIGITS];
   logic [DigitWidth-1:0]   entry_ff  [CODE_DIGITS];
   logic [DigitWidth-1:0]   default_digits [CODE_DIGITS];
   logic [DigitWidth-1:0]   reset_digits   [CODE_DIGITS];
   logic [DigitWidth-1:0]   full_entry     [CODE_DIGITS];
   logic [CntWidth-1:0]     count_ff, count_in;
   logic                    allowed_ff, allowed_in;
   logic                    verified_ff, verified_in;
   logic                    take_digit;
   logic                    entry_done;
   logic                    entry_match;
   logic                    start;
   logic [MsWidth-1:0]      dur;
   logic [CntWidth+2:0]     count_ext;
   logic [IdxWidth-1:0]     wr_idx;

   // Split configured and reset default codes into digits, most significant first
   for (genvar g = 0; g < CODE_DIGITS; g++) begin : g_digits
      localparam int unsigned Shift = 4 * (CODE_DIGITS - 1 - g);
      logic [CodeWidth-1:0] cfg_sh;
      logic [CodeWidth-1:0] rst_sh;
      assign cfg_sh = (Shift < CodeWidth) ? (cfg.default_code >> Shift) : '0;
      assign rst_sh = (Shift < CodeWidth) ? (DefaultCodeRst >> Shift) : '0;
      assign default_digits[g] = cfg_sh[DigitWidth-1:0];
      assign reset_digits[g]   = rst_sh[DigitWidth-1:0];
      // A completing entry has the current key in its last place
      assign full_entry[g] = (g == CODE_DIGITS - 1) ? evt_key : entry_ff[g];
   end

   // Compare the completed entry with the stored code
   always_comb begin
      entry_match = 1'b1;
      for (int i = 0; i < CODE_DIGITS; i++) begin
         if (full_entry[i] != stored_ff[i]) entry_match = 1'b0;
      end
   end

   assign wr_idx = count_ff[IdxWidth-1:0];
   assign take_digit = evt_fire && (kclc_mode_type'(evt_mode) == MODE_KEY) &&
                       ((stage_ff == STAGE_TRY_OPEN) || (stage_ff == STAGE_CHANGE)) &&
                       (count_ff < CntWidth'(CODE_DIGITS)) && (evt_key != KeyNone) &&
                       allowed_ff;
   assign entry_done = take_digit && (count_ff == LastCount);

   // Apply one event to the lock state
   always_comb begin
      stage_in    = stage_ff;
      stored_in   = stored_ff;
      count_in    = count_ff;
      allowed_in  = allowed_ff;
      verified_in = verified_ff;
      start       = 1'b0;
      dur         = '0;
      if (evt_fire) begin
         unique case (kclc_mode_type'(evt_mode))
            MODE_KEY: begin
               priority if (stage_ff == STAGE_MENU) begin
                  if (evt_key == KeyUnlock) stage_in = STAGE_TRY_OPEN;
                  else if (evt_key == KeyChange) stage_in = STAGE_CHANGE;
               end else if (take_digit) begin
                  count_in   = count_ff + CntWidth'(1);
                  allowed_in = 1'b0;
                  start      = 1'b1;
                  dur        = cfg.debounce_ms;
                  if (entry_done) begin
                     priority if (stage_ff == STAGE_TRY_OPEN) begin
                        if (entry_match) begin
                           stage_in = STAGE_OPEN;
                           dur      = cfg.open_ms;
                        end else begin
                           stage_in = STAGE_WRONG;
                           dur      = cfg.wrong_unlock_ms;
                        end
                     end else if (!verified_ff) begin
                        if (!entry_match) begin
                           stage_in = STAGE_WRONG;
                           dur      = cfg.wrong_change_ms;
                        end else begin
                           verified_in = 1'b1;
                        end
                     end else begin
                        stored_in   = full_entry;
                        stage_in    = STAGE_CODE_SET;
                        dur         = cfg.changed_ms;
                        verified_in = 1'b0;
                     end
                     count_in   = '0;
                     allowed_in = 1'b1;
                  end
               end else begin
                  stage_in = stage_ff;
               end
            end
            MODE_TIMER: begin
               if ((stage_ff == STAGE_TRY_OPEN) || (stage_ff == STAGE_CHANGE)) begin
                  allowed_in = 1'b1;
               end else if ((stage_ff == STAGE_OPEN) || (stage_ff == STAGE_WRONG) ||
                            (stage_ff == STAGE_CODE_SET) || (stage_ff == STAGE_RESTORED)) begin
                  stage_in = STAGE_MENU;
               end
            end
            MODE_RESET: begin
               stage_in    = STAGE_RESTORED;
               stored_in   = default_digits;
               count_in    = '0;
               allowed_in  = 1'b1;
               verified_in = 1'b0;
               start       = 1'b1;
               dur         = cfg.reset_notice_ms;
            end
            default: begin
               stage_in = stage_ff;
            end
         endcase
      end
   end

   // Hold lock state
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff    <= STAGE_MENU;
         stored_ff   <= reset_digits;
         count_ff    <= '0;
         allowed_ff  <= 1'b1;
         verified_ff <= 1'b0;
      end else begin
         stage_ff    <= stage_in;
         stored_ff   <= stored_in;
         count_ff    <= count_in;
         allowed_ff  <= allowed_in;
         verified_ff <= verified_in;
      end
   end

   // Store the accepted digit
   always_ff @(posedge clock) begin
      if (take_digit) begin
         entry_ff[wr_idx] <= evt_key;
      end
   end

   // Build the result from the updated state
   assign count_ext = (CntWidth + 3)'(count_in);
   always_comb begin
      rsp.stage             = stage_in;
      rsp.start_timer       = start;
      rsp.timer_ms          = start ? dur : '0;
      rsp.digits_entered    = count_ext[2:0];
      rsp.last_digit_shown  = ((stage_in == STAGE_TRY_OPEN) || (stage_in == STAGE_CHANGE)) &&
                              (count_in != '0) && !allowed_in;
      rsp.old_code_verified = verified_in;
      rsp.door_open         = (stage_in == STAGE_OPEN);
   end

endmodule
`default_nettype wire

/* src/keypad_code_lock_controller_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Keypad code lock controller
// Code lock driven by key, timer expiry and reset button events.
// ----------------------------------------------------------------------------
// Each accepted event returns exactly one result transaction. An event is
// captured in an input register, applied to the lock state once the output
// register is free, and its result is registered in the output register,
// which drives rsp_tvalid. One event is taken every cycle while the result
// side keeps up; the rate is set by the single state update in the lock
// core. Configuration takes effect for the next event; a new default code
// is loaded into the stored code at the next reset button event.
module keypad_code_lock_controller_unit #(
   parameter int unsigned CODE_DIGITS = 6
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // event channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [3:0] key, [7:4] zero
   input  wire logic [1:0]  req_tuser,   // [1:0] mode
   // result channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // [2:0] stage, [3] start_timer, [19:4] timer_ms,
                                         // [22:20] digits_entered, [23] last_digit_shown,
                                         // [24] old_code_verified, [25] door_open, [31:26] zero
   // configuration
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_addr,
   input  wire logic [23:0] csr_wdata
);
   import kclc_pkg::*;

   logic                 in_valid_ff;
   logic [ModeWidth-1:0] in_mode_ff;
   logic [KeyWidth-1:0]  in_key_ff;
   logic                 out_valid_ff;
   kclc_rsp_type         out_ff;
   kclc_rsp_type         core_rsp;
   kclc_cfg_type         cfg;
   logic                 advance;
   logic                 out_free;

   kclc_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   kclc_core #(
      .CODE_DIGITS (CODE_DIGITS)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .evt_fire (advance),
      .evt_mode (in_mode_ff),
      .evt_key  (in_key_ff),
      .cfg      (cfg),
      .rsp      (core_rsp)
   );

   assign out_free   = !out_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;

   // Capture the event transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_mode_ff <= req_tuser;
         in_key_ff  <= req_tdata[KeyWidth-1:0];
      end
   end

   // Hold the result until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= core_rsp;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'd0, out_ff};

endmodule
`default_nettype wire
